FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/skc_pkg.sv
package skc_pkg;

   localparam int CHROMA_W    = 8;
   localparam int CSR_INDEX_W = 3;

   // squared chroma distance and its Q9.8 root
   localparam int D2_W     = 17;
   localparam int X_FRAC_W = 16;
   localparam int ROOT_W   = 17;
   localparam int X_W      = 2 * ROOT_W;
   localparam int REM_W    = ROOT_W + 2;

   // blend divider operands (Q8.8 radii)
   localparam int DIV_W = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_CB,
      CSR_KEY_CR,
      CSR_TOLERANCE_RADIUS,
      CSR_SOFTNESS_WIDTH,
      CSR_BLUE_TINT,
      CSR_RED_TINT,
      CSR_CHROMA_FLOOR,
      CSR_CHROMA_CEILING
   } csr_index_type;

   typedef enum logic [1:0] {
      BLEND_ZERO,
      BLEND_FULL,
      BLEND_BAND
   } blend_class_type;

   typedef struct packed {
      logic [CHROMA_W-1:0] luma;
      logic [CHROMA_W-1:0] cb;
      logic [CHROMA_W-1:0] cr;
      logic [CHROMA_W-1:0] dest_cb;
      logic [CHROMA_W-1:0] dest_cr;
   } pix_type;

   typedef struct packed {
      blend_class_type cls;
      pix_type         pix;
   } div_tag_type;

endpackage

FILE: design/soft_chroma_key_recolor_core.sv
// Soft chroma key recolor: one YCbCr pixel per item, one result item per pixel.
// The core takes a pixel on every clock and delivers one on every clock while
// rsp_ready stays high. Behind the input lie the 17-stage square root of the
// chroma distance and the BLEND_FRAC_BITS + 1 stage blend divider, each
// retiring one result bit per stage, plus six stages of multiply, round and
// clamp. A two-entry output buffer lets the core keep taking pixels while a
// result waits; the pipeline holds only once both entries are full. Registers
// are to be written through the csr port only while no pixel is in flight;
// the core itself does not enforce this. There is no clearing pass after reset.
`include "assert_macros.svh"

module soft_chroma_key_recolor_core
   import skc_pkg::*;
#(
   parameter int BLEND_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CHROMA_W-1:0]    req_luma_in,
   input  logic [CHROMA_W-1:0]    req_blue_diff_in,
   input  logic [CHROMA_W-1:0]    req_red_diff_in,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHROMA_W-1:0]    rsp_luma_out,
   output logic [CHROMA_W-1:0]    rsp_blue_diff_out,
   output logic [CHROMA_W-1:0]    rsp_red_diff_out,

   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CHROMA_W-1:0]    csr_wdata
);

   localparam int QUO_W   = BLEND_FRAC_BITS + 1;
   localparam int PROD_W  = QUO_W + 10;
   localparam int TPROD_W = 26;

   localparam logic [QUO_W-1:0]  FULL_BLEND = QUO_W'(1) << BLEND_FRAC_BITS;
   localparam logic [PROD_W-1:0] TRUNC_BIAS = (PROD_W'(1) << BLEND_FRAC_BITS) - PROD_W'(1);

   localparam logic [15:0]        SCALE_CB_Q16 = 16'd32244;
   localparam logic [15:0]        SCALE_CR_Q16 = 16'd57475;
   localparam logic [TPROD_W-1:0] ROUND_HALF   = TPROD_W'(32768);
   localparam logic [TPROD_W-1:0] Q16_BIAS     = TPROD_W'(65535);
   localparam logic [10:0]        CHROMA_MID   = 11'd128;

   localparam logic [CHROMA_W-1:0] KEY_CB_RESET    = 8'd128;
   localparam logic [CHROMA_W-1:0] KEY_CR_RESET    = 8'd128;
   localparam logic [CHROMA_W-1:0] TOLERANCE_RESET = 8'd60;
   localparam logic [CHROMA_W-1:0] SOFTNESS_RESET  = 8'd20;
   localparam logic [CHROMA_W-1:0] BLUE_TINT_RESET = 8'd200;
   localparam logic [CHROMA_W-1:0] RED_TINT_RESET  = 8'd20;
   localparam logic [CHROMA_W-1:0] FLOOR_RESET     = 8'd16;
   localparam logic [CHROMA_W-1:0] CEILING_RESET   = 8'd240;

   function automatic logic [CHROMA_W-1:0] clamp_chroma(
      input logic signed [10:0]  value,
      input logic [CHROMA_W-1:0] lo,
      input logic [CHROMA_W-1:0] hi
   );
      logic [CHROMA_W-1:0] result;
      priority if (value < $signed({3'b000, lo})) begin
         result = lo;
      end else if (value > $signed({3'b000, hi})) begin
         result = hi;
      end else begin
         result = value[CHROMA_W-1:0];
      end
      return result;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [CHROMA_W-1:0] key_cb_ff, key_cr_ff, tolerance_ff, softness_ff;
   logic [CHROMA_W-1:0] blue_tint_ff, red_tint_ff, floor_ff, ceiling_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_cb_ff    <= KEY_CB_RESET;
         key_cr_ff    <= KEY_CR_RESET;
         tolerance_ff <= TOLERANCE_RESET;
         softness_ff  <= SOFTNESS_RESET;
         blue_tint_ff <= BLUE_TINT_RESET;
         red_tint_ff  <= RED_TINT_RESET;
         floor_ff     <= FLOOR_RESET;
         ceiling_ff   <= CEILING_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_CB:           key_cb_ff    <= csr_wdata;
            CSR_KEY_CR:           key_cr_ff    <= csr_wdata;
            CSR_TOLERANCE_RADIUS: tolerance_ff <= csr_wdata;
            CSR_SOFTNESS_WIDTH:   softness_ff  <= csr_wdata;
            CSR_BLUE_TINT:        blue_tint_ff <= csr_wdata;
            CSR_RED_TINT:         red_tint_ff  <= csr_wdata;
            CSR_CHROMA_FLOOR:     floor_ff     <= csr_wdata;
            CSR_CHROMA_CEILING:   ceiling_ff   <= csr_wdata;
         endcase
      end
   end

   // ------------------------------------------------------------ flow control
   logic go;
   logic skid_valid_ff;

   assign go        = !skid_valid_ff;
   assign req_ready = go;

   // ------------------------------------------ stage 1: squares, tint products
   logic signed [8:0]         du, dv, tdiff_cb, tdiff_cr;
   logic signed [17:0]        du_sq, dv_sq;
   logic signed [TPROD_W-1:0] tprod_cb, tprod_cr;

   assign du       = $signed({1'b0, req_blue_diff_in}) - $signed({1'b0, key_cb_ff});
   assign dv       = $signed({1'b0, req_red_diff_in}) - $signed({1'b0, key_cr_ff});
   assign du_sq    = du * du;
   assign dv_sq    = dv * dv;
   assign tdiff_cb = $signed({1'b0, blue_tint_ff}) - $signed({1'b0, req_luma_in});
   assign tdiff_cr = $signed({1'b0, red_tint_ff}) - $signed({1'b0, req_luma_in});
   assign tprod_cb = tdiff_cb * $signed({1'b0, SCALE_CB_Q16});
   assign tprod_cr = tdiff_cr * $signed({1'b0, SCALE_CR_Q16});

   logic                      s1_valid_ff;
   logic [15:0]               s1_du2_ff, s1_dv2_ff;
   logic signed [TPROD_W-1:0] s1_tprod_cb_ff, s1_tprod_cr_ff;
   logic [CHROMA_W-1:0]       s1_luma_ff, s1_cb_ff, s1_cr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (go) begin
         s1_valid_ff <= req_valid;
      end
      if (go) begin
         s1_du2_ff      <= du_sq[15:0];
         s1_dv2_ff      <= dv_sq[15:0];
         s1_tprod_cb_ff <= tprod_cb;
         s1_tprod_cr_ff <= tprod_cr;
         s1_luma_ff     <= req_luma_in;
         s1_cb_ff       <= req_blue_diff_in;
         s1_cr_ff       <= req_red_diff_in;
      end
   end

   // ------------------------------------------- stage 2: distance sum, round
   logic                      s2_valid_ff;
   logic [D2_W-1:0]           s2_d2_ff;
   logic signed [TPROD_W-1:0] s2_tv_cb_ff, s2_tv_cr_ff;
   logic [CHROMA_W-1:0]       s2_luma_ff, s2_cb_ff, s2_cr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (go) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (go) begin
         s2_d2_ff    <= {1'b0, s1_du2_ff} + {1'b0, s1_dv2_ff};
         s2_tv_cb_ff <= s1_tprod_cb_ff + $signed(ROUND_HALF);
         s2_tv_cr_ff <= s1_tprod_cr_ff + $signed(ROUND_HALF);
         s2_luma_ff  <= s1_luma_ff;
         s2_cb_ff    <= s1_cb_ff;
         s2_cr_ff    <= s1_cr_ff;
      end
   end

   // ----------------------------------------------- stage 3: tint targets
   logic signed [TPROD_W-1:0] tr_cb, tr_cr;
   logic signed [10:0]        tbase_cb, tbase_cr;
   pix_type                   s3_pix_in;

   // bias negative values so the shift truncates toward zero
   assign tr_cb    = s2_tv_cb_ff + (s2_tv_cb_ff[TPROD_W-1] ? $signed(Q16_BIAS) : '0);
   assign tr_cr    = s2_tv_cr_ff + (s2_tv_cr_ff[TPROD_W-1] ? $signed(Q16_BIAS) : '0);
   assign tbase_cb = $signed(CHROMA_MID) + $signed({tr_cb[25], tr_cb[25:16]});
   assign tbase_cr = $signed(CHROMA_MID) + $signed({tr_cr[25], tr_cr[25:16]});

   always_comb begin
      s3_pix_in.luma    = s2_luma_ff;
      s3_pix_in.cb      = s2_cb_ff;
      s3_pix_in.cr      = s2_cr_ff;
      s3_pix_in.dest_cb = clamp_chroma(tbase_cb, floor_ff, ceiling_ff);
      s3_pix_in.dest_cr = clamp_chroma(tbase_cr, floor_ff, ceiling_ff);
   end

   logic            s3_valid_ff;
   logic [D2_W-1:0] s3_d2_ff;
   pix_type         s3_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (go) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (go) begin
         s3_d2_ff  <= s2_d2_ff;
         s3_pix_ff <= s3_pix_in;
      end
   end

   // ------------------------------------------------------ Q9.8 distance
   logic                     sq_valid;
   logic [ROOT_W-1:0]        sq_dist;
   logic [$bits(pix_type)-1:0] sq_tag;
   pix_type                  sq_pix;

   skc_sqrt_pipe #(
      .TAG_W ($bits(pix_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (go),
      .in_valid  (s3_valid_ff),
      .in_d2     (s3_d2_ff),
      .in_tag    (s3_pix_ff),
      .out_valid (sq_valid),
      .out_root  (sq_dist),
      .out_tag   (sq_tag)
   );

   assign sq_pix = pix_type'(sq_tag);

   // ------------------------------------------- stage 4: classify, numerator
   logic [CHROMA_W-1:0] inner, band_width;
   logic [DIV_W-1:0]    inner_q, outer_q;
   blend_class_type     cls_in;

   assign inner      = (tolerance_ff > softness_ff) ? (tolerance_ff - softness_ff) : '0;
   assign band_width = tolerance_ff - inner;
   assign inner_q    = {inner, 8'h00};
   assign outer_q    = {tolerance_ff, 8'h00};

   always_comb begin
      priority if (sq_dist < {1'b0, inner_q}) begin
         cls_in = BLEND_FULL;
      end else if ((sq_dist < {1'b0, outer_q}) && (band_width != '0)) begin
         cls_in = BLEND_BAND;
      end else begin
         cls_in = BLEND_ZERO;
      end
   end

   logic             s4_valid_ff;
   logic [DIV_W-1:0] s4_num_ff, s4_den_ff;
   div_tag_type      s4_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (go) begin
         s4_valid_ff <= sq_valid;
      end
      if (go) begin
         s4_num_ff     <= outer_q - sq_dist[DIV_W-1:0];
         s4_den_ff     <= {band_width, 8'h00};
         s4_tag_ff.cls <= cls_in;
         s4_tag_ff.pix <= sq_pix;
      end
   end

   // ------------------------------------------------------ band blend weight
   logic                           div_valid;
   logic [QUO_W-1:0]               div_quo;
   logic [$bits(div_tag_type)-1:0] div_tag_raw;
   div_tag_type                    div_tag;

   skc_div_pipe #(
      .FRAC_BITS (BLEND_FRAC_BITS),
      .TAG_W     ($bits(div_tag_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (go),
      .in_valid  (s4_valid_ff),
      .in_num    (s4_num_ff),
      .in_den    (s4_den_ff),
      .in_tag    (s4_tag_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag_raw)
   );

   assign div_tag = div_tag_type'(div_tag_raw);

   // --------------------------------------------------- stage 5: blend product
   logic [QUO_W-1:0]         blend;
   logic signed [8:0]        cdiff_cb, cdiff_cr;
   logic signed [PROD_W-1:0] bprod_cb, bprod_cr;

   always_comb begin
      unique case (div_tag.cls)
         BLEND_FULL: blend = FULL_BLEND;
         BLEND_BAND: blend = div_quo;
         default:    blend = '0;
      endcase
   end

   assign cdiff_cb = $signed({1'b0, div_tag.pix.dest_cb}) - $signed({1'b0, div_tag.pix.cb});
   assign cdiff_cr = $signed({1'b0, div_tag.pix.dest_cr}) - $signed({1'b0, div_tag.pix.cr});
   assign bprod_cb = $signed({1'b0, blend}) * cdiff_cb;
   assign bprod_cr = $signed({1'b0, blend}) * cdiff_cr;

   logic                     s5_valid_ff, s5_active_ff;
   logic signed [PROD_W-1:0] s5_prod_cb_ff, s5_prod_cr_ff;
   logic [CHROMA_W-1:0]      s5_luma_ff, s5_cb_ff, s5_cr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (go) begin
         s5_valid_ff <= div_valid;
      end
      if (go) begin
         s5_active_ff  <= (blend != '0);
         s5_prod_cb_ff <= bprod_cb;
         s5_prod_cr_ff <= bprod_cr;
         s5_luma_ff    <= div_tag.pix.luma;
         s5_cb_ff      <= div_tag.pix.cb;
         s5_cr_ff      <= div_tag.pix.cr;
      end
   end

   // ------------------------------------------ stage 6: truncate toward zero
   logic signed [PROD_W-1:0] br_cb, br_cr;

   assign br_cb = s5_prod_cb_ff + (s5_prod_cb_ff[PROD_W-1] ? $signed(TRUNC_BIAS) : '0);
   assign br_cr = s5_prod_cr_ff + (s5_prod_cr_ff[PROD_W-1] ? $signed(TRUNC_BIAS) : '0);

   logic                s6_valid_ff, s6_active_ff;
   logic signed [9:0]   s6_step_cb_ff, s6_step_cr_ff;
   logic [CHROMA_W-1:0] s6_luma_ff, s6_cb_ff, s6_cr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (go) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (go) begin
         s6_active_ff  <= s5_active_ff;
         s6_step_cb_ff <= br_cb[BLEND_FRAC_BITS+9:BLEND_FRAC_BITS];
         s6_step_cr_ff <= br_cr[BLEND_FRAC_BITS+9:BLEND_FRAC_BITS];
         s6_luma_ff    <= s5_luma_ff;
         s6_cb_ff      <= s5_cb_ff;
         s6_cr_ff      <= s5_cr_ff;
      end
   end

   // ------------------------------------------------- final sum and clamp
   logic signed [10:0]  sum_cb, sum_cr;
   logic [CHROMA_W-1:0] fin_cb, fin_cr;

   assign sum_cb = $signed({3'b000, s6_cb_ff}) + $signed({s6_step_cb_ff[9], s6_step_cb_ff});
   assign sum_cr = $signed({3'b000, s6_cr_ff}) + $signed({s6_step_cr_ff[9], s6_step_cr_ff});
   // zero weight leaves the chroma untouched, unclamped
   assign fin_cb = s6_active_ff ? clamp_chroma(sum_cb, floor_ff, ceiling_ff) : s6_cb_ff;
   assign fin_cr = s6_active_ff ? clamp_chroma(sum_cr, floor_ff, ceiling_ff) : s6_cr_ff;

   // ------------------------------------------- output register and skid
   logic                out_valid_ff;
   logic [CHROMA_W-1:0] out_luma_ff, out_cb_ff, out_cr_ff;
   logic [CHROMA_W-1:0] skid_luma_ff, skid_cb_ff, skid_cr_ff;
   logic                push, take;

   assign push = go && s6_valid_ff;
   assign take = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         out_valid_ff <= 1'b1;
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end

      if (skid_valid_ff) begin
         if (take) begin
            out_luma_ff <= skid_luma_ff;
            out_cb_ff   <= skid_cb_ff;
            out_cr_ff   <= skid_cr_ff;
         end
      end else if (push) begin
         // park the item when the output register is still occupied
         if (out_valid_ff && !take) begin
            skid_luma_ff <= s6_luma_ff;
            skid_cb_ff   <= fin_cb;
            skid_cr_ff   <= fin_cr;
         end else begin
            out_luma_ff <= s6_luma_ff;
            out_cb_ff   <= fin_cb;
            out_cr_ff   <= fin_cr;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_luma_out      = out_luma_ff;
   assign rsp_blue_diff_out = out_cb_ff;
   assign rsp_red_diff_out  = out_cr_ff;

   // ------------------------------------------------------------ assertions
   logic skid_take, band_out;

   assign skid_take = skid_valid_ff && rsp_ready;
   assign band_out  = div_valid && (div_tag.cls == BLEND_BAND);

   `ASSERT_IMPLIES(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_skid_drains, clock, reset, skid_take, out_valid_ff && !skid_valid_ff)
   `ASSERT_IMPLIES(a_band_weight_bound, clock, reset, band_out, div_quo <= FULL_BLEND)

endmodule

FILE: design/skc_sqrt_pipe.sv
module skc_sqrt_pipe
   import skc_pkg::*;
#(
   parameter int TAG_W = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [D2_W-1:0]   in_d2,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [TAG_W-1:0]  out_tag
);

   logic              valid_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [D2_W-1:0]   d2_ff    [ROOT_W];
   logic [TAG_W-1:0]  tag_ff   [ROOT_W];

   // one root bit per stage, radicand is d2 * 2^16
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int P = ROOT_W - 1 - k;

      logic              valid_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [D2_W-1:0]   d2_prev;
      logic [TAG_W-1:0]  tag_prev;
      logic [X_W-1:0]    x_word;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_head
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign d2_prev    = in_d2;
         assign tag_prev   = in_tag;
      end else begin : g_body
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign d2_prev    = d2_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      assign x_word  = X_W'({d2_prev, {X_FRAC_W{1'b0}}});
      assign rem_sh  = {rem_prev[REM_W-3:0], x_word[2*P+1 -: 2]};
      assign trial   = {root_prev, 2'b01};
      assign ge      = (rem_sh >= trial);
      assign rem_in  = ge ? (rem_sh - trial) : rem_sh;
      assign root_in = {root_prev[ROOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            d2_ff[k]   <= d2_prev;
            tag_ff[k]  <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

FILE: design/skc_div_pipe.sv
module skc_div_pipe
   import skc_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int TAG_W     = 42
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [DIV_W-1:0]   in_num,
   input  logic [DIV_W-1:0]   in_den,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output logic [FRAC_BITS:0] out_quo,
   output logic [TAG_W-1:0]   out_tag
);

   localparam int QUO_W = FRAC_BITS + 1;

   logic             valid_ff [QUO_W];
   logic [DIV_W-1:0] rem_ff   [QUO_W];
   logic [DIV_W-1:0] den_ff   [QUO_W];
   logic [QUO_W-1:0] quo_ff   [QUO_W];
   logic [TAG_W-1:0] tag_ff   [QUO_W];

   // restoring division, one quotient bit per stage; the head stage yields the
   // integer bit, which is set when the numerator is at least the divisor
   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic             valid_prev;
      logic [DIV_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [DIV_W:0]   rem_sh;
      logic [DIV_W:0]   diff;
      logic             ge;
      logic [DIV_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (k == 0) begin : g_head
         assign valid_prev = in_valid;
         assign den_prev   = in_den;
         assign quo_prev   = '0;
         assign tag_prev   = in_tag;
         assign rem_sh     = {1'b0, in_num};
      end else begin : g_body
         assign valid_prev = valid_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
         assign rem_sh     = {rem_ff[k-1], 1'b0};
      end

      assign diff   = rem_sh - {1'b0, den_prev};
      assign ge     = (rem_sh >= {1'b0, den_prev});
      assign rem_in = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      assign quo_in = {quo_prev[QUO_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
         if (advance) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_in;
            tag_ff[k] <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_tag   = tag_ff[QUO_W-1];

endmodule
